/* rtl/elmd_pkg.sv */
// Package: constants, types and codes of the exclusion lattice block.
package elmd_pkg;

  // Ring geometry
  localparam int SITES      = 512;
  localparam int SITE_W     = $clog2(SITES);
  localparam int ROW_LG     = 3;
  localparam int ROW_W      = 1 << ROW_LG;
  localparam int NROWS      = SITES / ROW_W;
  localparam int ROW_IW     = SITE_W - ROW_LG;
  localparam int NBANKS     = 2;
  localparam int BANK_DEPTH = NROWS / NBANKS;

  // Field widths
  localparam int FUNC_W     = 2;
  localparam int SITE_FW    = 9;
  localparam int DRAW_W     = 16;
  localparam int RATE_W     = 17;
  localparam int PERIOD_W   = 21;
  localparam int STEPS_W    = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;

  // Result queue
  localparam int OUT_DEPTH  = 3;
  localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

  // Register reset values
  localparam logic [RATE_W-1:0]   RATE_AT_DEFECT_RST = RATE_W'(65536);
  localparam logic [PERIOD_W-1:0] PERIOD_RST         = PERIOD_W'(4096);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE   = 2'd0,
    FUNC_UPDATE  = 2'd1,
    FUNC_RESTART = 2'd2
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RATE_AT_DEFECT   = 3'd0,
    CFG_RATE_TOWARD_NEAR = 3'd1,
    CFG_RATE_AWAY_NEAR   = 3'd2,
    CFG_RATE_TOWARD_FAR  = 3'd3,
    CFG_RATE_BULK        = 3'd4,
    CFG_DEFECT_PERIOD    = 3'd5
  } cfg_idx_e;

  typedef logic [SITE_W-1:0] site_t;
  typedef logic [ROW_IW-1:0] row_idx_t;
  typedef logic [ROW_W-1:0]  row_t;

  typedef struct packed {
    logic               behind_occupied;
    logic               at_occupied;
    logic [SITE_FW-1:0] defect_position;
  } result_t;

endpackage

/* rtl/elmd_if.sv */
// Interfaces: input item channel and result channel.
interface elmd_in_if import elmd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [SITE_FW-1:0] site;
  logic               occupancy;
  logic               coin;
  logic [DRAW_W-1:0]  draw;

  modport source (output valid, func, site, occupancy, coin, draw, input ready);
  modport sink   (input valid, func, site, occupancy, coin, draw, output ready);
endinterface

interface elmd_out_if import elmd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               behind_occupied;
  logic               at_occupied;
  logic [SITE_FW-1:0] defect_position;

  modport source (output valid, behind_occupied, at_occupied, defect_position, input ready);
  modport sink   (input valid, behind_occupied, at_occupied, defect_position, output ready);
endinterface

/* rtl/elmd_ram.sv */
// Generic RAM: one write port, two registered read ports, read-before-write.
module elmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

/* rtl/elmd_out_fifo.sv */
// Result queue: small circular buffer between the update stage and the result channel.
module elmd_out_fifo import elmd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  result_t              push_item_i,
  input  logic                 pop_i,
  output result_t              head_o,
  output logic                 valid_o,
  output logic [OUT_CNT_W-1:0] count_o
);

  result_t                entries_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]   wptr_q, wptr_d;
  logic [OUT_PTR_W-1:0]   rptr_q, rptr_d;
  logic [OUT_CNT_W-1:0]   cnt_q, cnt_d;

  function automatic logic [OUT_PTR_W-1:0] ptr_inc(logic [OUT_PTR_W-1:0] p);
    return (p == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : OUT_PTR_W'(p + 1'b1);
  endfunction

  always_comb begin
    wptr_d = push_i ? ptr_inc(wptr_q) : wptr_q;
    rptr_d = pop_i ? ptr_inc(rptr_q) : rptr_q;
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = OUT_CNT_W'(cnt_q + 1'b1);
      2'b01:   cnt_d = OUT_CNT_W'(cnt_q - 1'b1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wptr_q] <= push_item_i;
    end
  end

  assign head_o  = entries_q[rptr_q];
  assign valid_o = (cnt_q != '0);
  assign count_o = cnt_q;

endmodule

/* rtl/exclusion_lattice_moving_defect.sv */
// Top level: moving-defect exclusion ring, one item per cycle unless stalled.
//
// Usage
//  - in_i carries items: func WRITE sets one site, UPDATE tries one particle
//    hop and counts a step, RESTART empties the ring and zeroes defect and
//    step count. A transfer happens when valid and ready are both high.
//  - out_o carries one sample each time the defect moves (every
//    defect_period updates): occupancy behind and at the new defect site,
//    and the new defect position.
//  - cfg_we_i/cfg_index_i/cfg_data_i write the rate and period registers;
//    write them only while the block is idle.
// Timing
//  - One item per cycle sustained while the result queue has room. An item
//    accepted is evaluated in the cycle after, from the bank RAM read data;
//    its sample is registered in the result queue before it shows on out_o.
//    The rate is set by the single pass through the two ring banks (one
//    read of the hop window and one read of the defect window per bank per
//    cycle).
// Reset and stall
//  - Reset empties the ring at once through per-row valid bits; no clearing
//    pass. RESTART does the same in its own cycle.
//  - A 3-entry result queue absorbs receiver stalls; in_i.ready drops only
//    when queued results plus the item in flight would fill it.
module exclusion_lattice_moving_defect import elmd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  elmd_in_if.sink               in_i,
  elmd_out_if.source            out_o
);

  // ring index helpers
  function automatic row_idx_t row_inc(row_idx_t r);
    return (32'(r) == NROWS - 1) ? '0 : row_idx_t'(r + 1'b1);
  endfunction

  function automatic row_idx_t row_dec(row_idx_t r);
    return (r == '0) ? row_idx_t'(NROWS - 1) : row_idx_t'(r - 1'b1);
  endfunction

  function automatic site_t site_inc(site_t s);
    return (32'(s) == SITES - 1) ? '0 : site_t'(s + 1'b1);
  endfunction

  localparam logic [ROW_LG-1:0] LAST_LO = ROW_LG'(ROW_W - 1);

  // config registers
  logic [RATE_W-1:0]   rate_at_defect_q, rate_toward_near_q, rate_away_near_q;
  logic [RATE_W-1:0]   rate_toward_far_q, rate_bulk_q;
  logic [PERIOD_W-1:0] defect_period_q;

  // block state
  site_t                defect_q, defect_d;
  logic [STEPS_W-1:0]   steps_q, steps_d;
  logic [NROWS-1:0]     row_valid_q, row_valid_d;

  // last row written per bank, covers the read-before-write RAM
  logic                 lw_v_q    [NBANKS];
  logic                 lw_v_d    [NBANKS];
  row_idx_t             lw_row_q  [NBANKS];
  row_t                 lw_data_q [NBANKS];

  // evaluation stage registers
  logic                 s1_valid_q;
  logic [FUNC_W-1:0]    s1_func_q;
  site_t                s1_site_q;
  logic                 s1_in_range_q;
  logic                 s1_occ_q;
  logic                 s1_coin_q;
  logic [DRAW_W-1:0]    s1_draw_q;

  // bank ports
  row_idx_t             a_nb_row  [NBANKS];
  row_idx_t             a_d_row   [NBANKS];
  row_t                 nb_rdata  [NBANKS];
  row_t                 d_rdata   [NBANKS];
  logic                 wr_en     [NBANKS];
  row_idx_t             wr_row    [NBANKS];
  row_t                 wr_data   [NBANKS];

  // fetch side
  logic                 in_acc;
  site_t                a_site;
  row_idx_t             a_rb, a_side, a_rd, a_rd1;

  // evaluation side
  row_idx_t             rb, side_row, rd, rd1;
  logic [ROW_LG-1:0]    lo, dlo;
  row_idx_t             nb_row [NBANKS];
  row_idx_t             d_row  [NBANKS];
  row_t                 nb_fix [NBANKS];
  row_t                 d_cur  [NBANKS];
  row_t                 main_row, side_dat, main_new, side_new;
  row_t                 drow0, drow1;
  logic                 main_we, side_we;
  logic                 cur, le, re;
  logic [SITE_W:0]      diff;
  site_t                off;
  logic [RATE_W-1:0]    rate_l, rate_r, rate_sel;
  logic                 first_right, go_right, hop_try, hop;
  logic                 is_write, is_update, is_restart, emit;
  result_t              res;

  logic [OUT_CNT_W-1:0] fifo_count;
  result_t              fifo_head;
  logic                 fifo_valid;

  // ---------------------------------------------------------------------
  // Config port
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_at_defect_q   <= RATE_AT_DEFECT_RST;
      rate_toward_near_q <= '0;
      rate_away_near_q   <= '0;
      rate_toward_far_q  <= '0;
      rate_bulk_q        <= '0;
      defect_period_q    <= PERIOD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_RATE_AT_DEFECT:   rate_at_defect_q   <= cfg_data_i[RATE_W-1:0];
        CFG_RATE_TOWARD_NEAR: rate_toward_near_q <= cfg_data_i[RATE_W-1:0];
        CFG_RATE_AWAY_NEAR:   rate_away_near_q   <= cfg_data_i[RATE_W-1:0];
        CFG_RATE_TOWARD_FAR:  rate_toward_far_q  <= cfg_data_i[RATE_W-1:0];
        CFG_RATE_BULK:        rate_bulk_q        <= cfg_data_i[RATE_W-1:0];
        CFG_DEFECT_PERIOD:    defect_period_q    <= cfg_data_i[PERIOD_W-1:0];
        default: ;  // unused index, ignored
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Fetch: read addresses go straight from the input port. The defect
  // window uses the defect position after the item now being evaluated.
  // ---------------------------------------------------------------------
  assign in_i.ready = ((OUT_CNT_W + 1)'(fifo_count) + (OUT_CNT_W + 1)'(s1_valid_q))
                      < (OUT_CNT_W + 1)'(OUT_DEPTH);
  assign in_acc = in_i.valid && in_i.ready;

  always_comb begin
    a_site = site_t'(in_i.site);
    a_rb   = a_site[SITE_W-1:ROW_LG];
    // left neighbor row at the row start, right neighbor row otherwise
    a_side = (a_site[ROW_LG-1:0] == '0) ? row_dec(a_rb) : row_inc(a_rb);
    a_rd   = defect_d[SITE_W-1:ROW_LG];
    a_rd1  = row_inc(a_rd);
    for (int j = 0; j < NBANKS; j++) begin
      a_nb_row[j] = (a_rb[0] == 1'(j)) ? a_rb : a_side;
      a_d_row[j]  = (a_rd[0] == 1'(j)) ? a_rd : a_rd1;
    end
  end

  // even rows in bank 0, odd rows in bank 1: a 3-site window never hits
  // one bank twice
  for (genvar j = 0; j < NBANKS; j++) begin : g_bank
    elmd_ram #(
      .WIDTH(ROW_W),
      .DEPTH(BANK_DEPTH)
    ) u_ram (
      .clk_i     (clk_i),
      .we_i      (wr_en[j]),
      .waddr_i   (wr_row[j][ROW_IW-1:1]),
      .wdata_i   (wr_data[j]),
      .raddr_a_i (a_nb_row[j][ROW_IW-1:1]),
      .rdata_a_o (nb_rdata[j]),
      .raddr_b_i (a_d_row[j][ROW_IW-1:1]),
      .rdata_b_o (d_rdata[j])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_func_q     <= in_i.func;
      s1_site_q     <= a_site;
      s1_in_range_q <= (32'(in_i.site) < SITES);
      s1_occ_q      <= in_i.occupancy;
      s1_coin_q     <= in_i.coin;
      s1_draw_q     <= in_i.draw;
    end
  end

  // ---------------------------------------------------------------------
  // Evaluate: one pass over the hop window and the defect window
  // ---------------------------------------------------------------------
  always_comb begin
    is_write   = s1_valid_q && (s1_func_q == FUNC_WRITE);
    is_update  = s1_valid_q && (s1_func_q == FUNC_UPDATE);
    is_restart = s1_valid_q && (s1_func_q == FUNC_RESTART);

    rb       = s1_site_q[SITE_W-1:ROW_LG];
    lo       = s1_site_q[ROW_LG-1:0];
    side_row = (lo == '0) ? row_dec(rb) : row_inc(rb);
    rd       = defect_q[SITE_W-1:ROW_LG];
    rd1      = row_inc(rd);
    dlo      = defect_q[ROW_LG-1:0];

    // current row contents: last write, then RAM if the row is live, else empty
    for (int j = 0; j < NBANKS; j++) begin
      nb_row[j] = (rb[0] == 1'(j)) ? rb : side_row;
      d_row[j]  = (rd[0] == 1'(j)) ? rd : rd1;
      if (lw_v_q[j] && (lw_row_q[j] == nb_row[j])) begin
        nb_fix[j] = lw_data_q[j];
      end else begin
        nb_fix[j] = row_valid_q[nb_row[j]] ? nb_rdata[j] : '0;
      end
    end
    main_row = nb_fix[rb[0]];
    side_dat = nb_fix[~rb[0]];

    cur = main_row[lo];
    le  = !((lo == '0) ? side_dat[ROW_W-1] : main_row[ROW_LG'(lo - 1'b1)]);
    re  = !((lo == LAST_LO) ? side_dat[0] : main_row[ROW_LG'(lo + 1'b1)]);

    // offset from the defect around the ring
    diff = {1'b0, s1_site_q} - {1'b0, defect_q};
    off  = diff[SITE_W] ? site_t'(diff + (SITE_W + 1)'(SITES)) : diff[SITE_W-1:0];

    first_right = 1'b1;
    priority if (off == '0) begin
      rate_l = rate_at_defect_q;
      rate_r = rate_at_defect_q;
    end else if (off == site_t'(SITES - 1)) begin
      rate_l = rate_away_near_q;
      rate_r = rate_toward_near_q;
    end else if (off == site_t'(1)) begin
      rate_l      = rate_toward_near_q;
      rate_r      = rate_away_near_q;
      first_right = 1'b0;
    end else if (off == site_t'(SITES - 2)) begin
      rate_l = rate_bulk_q;
      rate_r = rate_toward_far_q;
    end else if (off == site_t'(2)) begin
      rate_l      = rate_toward_far_q;
      rate_r      = rate_bulk_q;
      first_right = 1'b0;
    end else begin
      rate_l = rate_bulk_q;
      rate_r = rate_bulk_q;
    end

    // direction: both free -> coin picks, one free -> coin 0 only
    hop_try  = 1'b0;
    go_right = 1'b0;
    if (le && re) begin
      hop_try  = 1'b1;
      go_right = s1_coin_q ? !first_right : first_right;
    end else if ((le || re) && !s1_coin_q) begin
      hop_try  = 1'b1;
      go_right = re;
    end
    rate_sel = go_right ? rate_r : rate_l;
    hop = is_update && s1_in_range_q && cur && hop_try
          && (RATE_W'(s1_draw_q) < rate_sel);

    main_new = main_row;
    side_new = side_dat;
    main_we  = 1'b0;
    side_we  = 1'b0;
    if (is_write && s1_in_range_q) begin
      main_new[lo] = s1_occ_q;
      main_we      = 1'b1;
    end
    if (hop) begin
      main_new[lo] = 1'b0;
      main_we      = 1'b1;
      if (go_right) begin
        if (lo == LAST_LO) begin
          side_new[0] = 1'b1;
          side_we     = 1'b1;
        end else begin
          main_new[ROW_LG'(lo + 1'b1)] = 1'b1;
        end
      end else begin
        if (lo == '0) begin
          side_new[ROW_W-1] = 1'b1;
          side_we           = 1'b1;
        end else begin
          main_new[ROW_LG'(lo - 1'b1)] = 1'b1;
        end
      end
    end

    for (int j = 0; j < NBANKS; j++) begin
      wr_en[j]   = (rb[0] == 1'(j)) ? main_we : side_we;
      wr_row[j]  = nb_row[j];
      wr_data[j] = (rb[0] == 1'(j)) ? main_new : side_new;
      // defect window sees this item's hop
      if (wr_en[j] && (wr_row[j] == d_row[j])) begin
        d_cur[j] = wr_data[j];
      end else if (lw_v_q[j] && (lw_row_q[j] == d_row[j])) begin
        d_cur[j] = lw_data_q[j];
      end else begin
        d_cur[j] = row_valid_q[d_row[j]] ? d_rdata[j] : '0;
      end
    end
    drow0 = d_cur[rd[0]];
    drow1 = d_cur[~rd[0]];

    // defect move; a zero period behaves as one
    emit = is_update && ((PERIOD_W'(steps_q) + 1'b1) >= defect_period_q);

    res.behind_occupied = drow0[dlo];
    res.at_occupied     = (dlo == LAST_LO) ? drow1[0] : drow0[ROW_LG'(dlo + 1'b1)];
    res.defect_position = SITE_FW'(site_inc(defect_q));

    defect_d = defect_q;
    steps_d  = steps_q;
    if (is_restart) begin
      defect_d = '0;
      steps_d  = '0;
    end else if (emit) begin
      defect_d = site_inc(defect_q);
      steps_d  = '0;
    end else if (is_update) begin
      steps_d  = STEPS_W'(steps_q + 1'b1);
    end

    row_valid_d = row_valid_q;
    if (is_restart) begin
      row_valid_d = '0;
    end
    for (int j = 0; j < NBANKS; j++) begin
      lw_v_d[j] = is_restart ? 1'b0 : (lw_v_q[j] || wr_en[j]);
      if (wr_en[j]) begin
        row_valid_d[wr_row[j]] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      defect_q    <= '0;
      steps_q     <= '0;
      row_valid_q <= '0;
      for (int j = 0; j < NBANKS; j++) begin
        lw_v_q[j] <= 1'b0;
      end
    end else begin
      defect_q    <= defect_d;
      steps_q     <= steps_d;
      row_valid_q <= row_valid_d;
      for (int j = 0; j < NBANKS; j++) begin
        lw_v_q[j] <= lw_v_d[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < NBANKS; j++) begin
      if (wr_en[j]) begin
        lw_row_q[j]  <= wr_row[j];
        lw_data_q[j] <= wr_data[j];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result queue
  // ---------------------------------------------------------------------
  elmd_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (emit),
    .push_item_i (res),
    .pop_i       (out_o.valid && out_o.ready),
    .head_o      (fifo_head),
    .valid_o     (fifo_valid),
    .count_o     (fifo_count)
  );

  assign out_o.valid           = fifo_valid;
  assign out_o.behind_occupied = fifo_head.behind_occupied;
  assign out_o.at_occupied     = fifo_head.at_occupied;
  assign out_o.defect_position = fifo_head.defect_position;

endmodule

/* rtl/elmd_checker.sv */
// Checker: port-level assertions on the exclusion lattice top, with its bind.
module elmd_checker import elmd_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_behind,
  input logic               out_at,
  input logic [SITE_FW-1:0] out_pos
);

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable({out_behind, out_at, out_pos}))
    else $error("result changed while stalled");

  // input back-pressure only while results are pending
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  // a fresh result comes from an item taken earlier, through the evaluation stage and the result queue
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a matching input transfer");

endmodule

bind exclusion_lattice_moving_defect elmd_checker u_elmd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (in_i.valid),
  .in_ready   (in_i.ready),
  .out_valid  (out_o.valid),
  .out_ready  (out_o.ready),
  .out_behind (out_o.behind_occupied),
  .out_at     (out_o.at_occupied),
  .out_pos    (out_o.defect_position)
);
